// ===== rtl/core/lsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU stack distance miss counter package
// Shared types and constants of the front end and the execution back end.
// ----------------------------------------------------------------------------
package lsdm_pkg;

  localparam int ADDR_MAX_W = 32;
  localparam int COUNT_W    = 24;
  localparam int CNT_W      = 32;
  localparam int SIZE_W     = 9;
  localparam int LANE_W     = 2;
  localparam int MAX_LANES  = 4;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_D = 3'd4;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_RANGE  = 2'd1,
    OP_REPORT = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [ADDR_MAX_W-1:0] stride;
    logic [COUNT_W-1:0]    count;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_RNG_NEXT,
    ST_RNG_TAIL,
    ST_FILL,
    ST_REPORT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lsdm_front.sv =====
// ----------------------------------------------------------------------------
// LRU stack distance front end
// Accepts items, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
module lsdm_front #(
  parameter int ADDR_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [ADDR_BITS-1:0]        in_address,
  input  logic [ADDR_BITS-1:0]        in_stride,
  input  logic [lsdm_pkg::COUNT_W-1:0] in_count,
  output logic                        cmd_valid,
  output lsdm_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);
  import lsdm_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       keep;
  logic       push;
  cmd_t       new_cmd;

  always_comb begin
    case (in_operation) inside
      OP_ACCESS, OP_REPORT: keep = 1'b1;
      OP_RANGE:             keep = (in_count != '0);
      default:              keep = 1'b0;
    endcase
  end

  always_comb begin
    new_cmd.op     = op_t'(in_operation);
    new_cmd.addr   = ADDR_MAX_W'(in_address);
    new_cmd.stride = ADDR_MAX_W'(in_stride);
    new_cmd.count  = in_count;
  end

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/lsdm_back.sv =====
// ----------------------------------------------------------------------------
// LRU stack distance back end
// Walks the recency stack, expands ranges, keeps and reports miss counters.
// ----------------------------------------------------------------------------
module lsdm_back #(
  parameter int STACK_DEPTH = 256,
  parameter int ADDR_BITS   = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_valid,
  input  lsdm_pkg::cmd_t                           cmd,
  output logic                                     cmd_pop,
  input  logic [lsdm_pkg::ACT_W-1:0]               lanes,
  input  logic [lsdm_pkg::MAX_LANES-1:0][lsdm_pkg::SIZE_W-1:0] sizes,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [lsdm_pkg::LANE_W-1:0]              out_size_index,
  output logic [lsdm_pkg::CNT_W-1:0]               out_miss_count,
  output logic                                     out_last_result
);
  import lsdm_pkg::*;

  localparam int IDXW = $clog2(STACK_DEPTH);
  localparam int DW   = (IDXW + 1 > SIZE_W) ? IDXW + 1 : SIZE_W;
  localparam int PW   = (ADDR_BITS + 1 > 14) ? ADDR_BITS + 1 : 14;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(STACK_DEPTH - 1);

  logic [ADDR_BITS-1:0] tag_mem [STACK_DEPTH];
  logic [ADDR_BITS-1:0] rd_data_r;
  logic [IDXW-1:0]      rd_addr;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  logic [ADDR_BITS-1:0] mem_wdata;

  logic [STACK_DEPTH-1:0] valid_r;
  state_t                 state_r, state_nxt;
  logic [IDXW-1:0]        idx_r;
  logic [ADDR_BITS-1:0]   taddr_r, carry_r, base_r, stride_r, fill_addr_r;
  logic [COUNT_W-1:0]     count_r;
  logic [IDXW:0]          k_r, m_r;
  logic                   in_range_r;
  logic [IDXW-1:0]        fill_last_r;
  logic [LANE_W-1:0]      lane_r;
  logic [CNT_W-1:0]       cnt_r [MAX_LANES];
  logic                   out_valid_r;
  logic [LANE_W-1:0]      out_idx_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_last_r;

  logic                   hit, cur_valid, walk_end, more_touch, has_tail;
  logic                   out_load, lane_last;
  logic [IDXW:0]          k_inc;
  logic [IDXW:0]          m_new;
  logic [DW-1:0]          depth;
  logic [ADDR_BITS+COUNT_W-1:0] prod;
  logic [COUNT_W-1:0]     rest;
  logic [$clog2(ADDR_BITS+1)-1:0] tz;
  logic [PW-1:0]          period;
  logic                   period_big;
  logic [PW-1:0]          fill_n;

  assign cur_valid  = valid_r[idx_r];
  assign hit        = cur_valid && (rd_data_r == taddr_r);
  assign walk_end   = hit || !cur_valid || (idx_r == IDX_LAST);
  assign k_inc      = k_r + 1'b1;
  assign more_touch = in_range_r && (k_inc != m_r);
  assign has_tail   = in_range_r && (COUNT_W'(m_r) != count_r);
  assign depth      = DW'(idx_r) + DW'(1);
  assign lane_last  = ({1'b0, lane_r} == (lanes - ACT_W'(1)));
  assign out_load   = !out_valid_r || !out_stall;
  assign m_new      = (cmd.count < COUNT_W'(STACK_DEPTH)) ? (IDXW+1)'(cmd.count)
                                                         : (IDXW+1)'(STACK_DEPTH);

  assign prod   = ADDR_BITS'(stride_r) * (count_r - COUNT_W'(1));
  assign rest   = count_r - COUNT_W'(m_r);

  always_comb begin
    tz = '0;
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if (stride_r[i]) begin
        tz = ($clog2(ADDR_BITS+1))'(i);
      end
    end
    if (stride_r == '0) begin
      period = PW'(1);
    end else begin
      period = PW'(1) << (ADDR_BITS - int'(tz));
    end
    period_big = (period > PW'(STACK_DEPTH));
    fill_n     = period_big ? PW'(STACK_DEPTH) : period;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == OP_REPORT) ? ST_REPORT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          if (more_touch) begin
            state_nxt = ST_RNG_NEXT;
          end else if (has_tail) begin
            state_nxt = ST_RNG_TAIL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RNG_NEXT: state_nxt = ST_WALK;
      ST_RNG_TAIL: state_nxt = ST_FILL;
      ST_FILL: begin
        if (idx_r == fill_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_load && lane_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = carry_r;
    unique case (state_r)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_WALK: begin
        mem_we  = 1'b1;
        rd_addr = idx_r + 1'b1;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_addr_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LANES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (state_r == ST_WALK && walk_end) begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if ((ACT_W'(i) < lanes) && (!hit || (DW'(sizes[i]) < depth))) begin
            cnt_r[i] <= sat_add(cnt_r[i], CNT_W'(1));
          end
        end
      end
      if (state_r == ST_RNG_TAIL) begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if ((ACT_W'(i) < lanes) && (period_big || (PW'(sizes[i]) < period))) begin
            cnt_r[i] <= sat_add(cnt_r[i], CNT_W'(rest));
          end
        end
      end
      if (state_r == ST_REPORT) begin
        if (out_load) begin
          out_valid_r <= 1'b1;
          if (lane_last) begin
            for (int i = 0; i < MAX_LANES; i++) begin
              cnt_r[i] <= '0;
            end
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        idx_r      <= '0;
        lane_r     <= '0;
        k_r        <= '0;
        m_r        <= m_new;
        in_range_r <= (cmd.op == OP_RANGE);
        taddr_r    <= ADDR_BITS'(cmd.addr);
        carry_r    <= ADDR_BITS'(cmd.addr);
        base_r     <= ADDR_BITS'(cmd.addr);
        stride_r   <= ADDR_BITS'(cmd.stride);
        count_r    <= cmd.count;
      end
      ST_WALK: begin
        if (walk_end) begin
          k_r <= k_inc;
        end else begin
          carry_r <= rd_data_r;
          idx_r   <= idx_r + 1'b1;
        end
      end
      ST_RNG_NEXT: begin
        idx_r   <= '0;
        taddr_r <= taddr_r + stride_r;
        carry_r <= taddr_r + stride_r;
      end
      ST_RNG_TAIL: begin
        idx_r       <= '0;
        fill_addr_r <= base_r + prod[ADDR_BITS-1:0];
        fill_last_r <= IDXW'(fill_n - PW'(1));
      end
      ST_FILL: begin
        idx_r       <= idx_r + 1'b1;
        fill_addr_r <= fill_addr_r - stride_r;
      end
      ST_REPORT: begin
        if (out_load) begin
          out_idx_r  <= lane_r;
          out_cnt_r  <= cnt_r[lane_r];
          out_last_r <= lane_last;
          lane_r     <= lane_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_size_index  = out_idx_r;
  assign out_miss_count  = out_cnt_r;
  assign out_last_result = out_last_r;

endmodule

// ===== rtl/core/lru_stack_distance_miss_counter_unit.sv =====
// ----------------------------------------------------------------------------
// LRU stack distance miss counter
// Profiles one address stream against up to four fully associative LRU caches.
// ----------------------------------------------------------------------------
// The recency stack memory is walked one entry a cycle from the most recent
// entry until the address, an empty entry or the bottom is found. A range
// item performs min(count, STACK_DEPTH) such walks and, when count is larger,
// a fill of up to STACK_DEPTH entries. A report item gives one result a cycle
// per active size while out_stall is low. A two-item queue sits between the
// input and the stack walker.
module lru_stack_distance_miss_counter_unit #(
  parameter int STACK_DEPTH = 256,
  parameter int NUM_SIZES   = 4,
  parameter int ADDR_BITS   = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsdm_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  logic [ADDR_BITS-1:0]           in_stride,
  input  logic [lsdm_pkg::COUNT_W-1:0]   in_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lsdm_pkg::LANE_W-1:0]    out_size_index,
  output logic [lsdm_pkg::CNT_W-1:0]     out_miss_count,
  output logic                           out_last_result
);
  import lsdm_pkg::*;

  localparam int LANES = (NUM_SIZES < MAX_LANES) ? NUM_SIZES : MAX_LANES;

  logic [ACT_W-1:0]                  active_r;
  logic [MAX_LANES-1:0][SIZE_W-1:0]  size_r;
  logic [ACT_W-1:0]                  lanes;
  logic                              cmd_valid, cmd_pop;
  cmd_t                              cmd;

  always_comb begin
    if (active_r == '0) begin
      lanes = ACT_W'(1);
    end else if (active_r > ACT_W'(LANES)) begin
      lanes = ACT_W'(LANES);
    end else begin
      lanes = active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_W'(1);
      for (int i = 0; i < MAX_LANES; i++) begin
        size_r[i] <= SIZE_W'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE: active_r  <= cfg_wdata[ACT_W-1:0];
        REG_SIZE_A: size_r[0] <= cfg_wdata;
        REG_SIZE_B: size_r[1] <= cfg_wdata;
        REG_SIZE_C: size_r[2] <= cfg_wdata;
        REG_SIZE_D: size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lsdm_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_address   (in_address),
    .in_stride    (in_stride),
    .in_count     (in_count),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  lsdm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .lanes           (lanes),
    .sizes           (size_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_size_index  (out_size_index),
    .out_miss_count  (out_miss_count),
    .out_last_result (out_last_result)
  );

endmodule
